[rtl/core/clie_pkg.sv]
package clie_pkg;

  localparam int DefCapacity = 64;

  localparam int OpW       = 3;
  localparam int ValueW    = 32;
  localparam int StatusW   = 3;
  localparam int InTdataW  = 72;
  localparam int OutTdataW = 40;

  localparam logic [OpW-1:0] OP_FIRST  = 3'd0;
  localparam logic [OpW-1:0] OP_LAST   = 3'd1;
  localparam logic [OpW-1:0] OP_AFTER  = 3'd2;
  localparam logic [OpW-1:0] OP_BEFORE = 3'd3;
  localparam logic [OpW-1:0] OP_LIST   = 3'd4;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd1;
  localparam logic [StatusW-1:0] ST_EMPTY    = 3'd2;
  localparam logic [StatusW-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [StatusW-1:0] ST_ITEM     = 3'd4;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_SOLO,
    WR_NEW_HEAD,
    WR_NEW_PLINK,
    WR_NEW_P,
    WR_TGT,
    WR_TGT_HEAD,
    WR_PREV
  } wr_op_e;

  typedef struct packed {
    logic               ld_req;
    logic               rd_head;
    logic               rd_next;
    logic               save_node;
    wr_op_e             wr_op;
    logic               emit;
    logic               emit_item;
    logic [StatusW-1:0] emit_status;
    logic               emit_last;
  } cmd_t;

  typedef struct packed {
    logic nonempty;
    logic full;
    logic link_is_head;
    logic val_match;
    logic cur_is_head;
    logic cnt_end;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/clie_ctrl.sv]
module clie_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic [clie_pkg::OpW-1:0]   req_op_i,
  output logic                       req_ready_o,
  input  clie_pkg::sts_t             sts_i,
  output clie_pkg::cmd_t             cmd_o
);
  import clie_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SOLO     = 3'd1;
  localparam logic [2:0] S_TAIL     = 3'd2;
  localparam logic [2:0] S_SRCH     = 3'd3;
  localparam logic [2:0] S_LIST     = 3'd4;
  localparam logic [2:0] S_LNK_TGT  = 3'd5;
  localparam logic [2:0] S_LNK_PREV = 3'd6;
  localparam logic [2:0] S_EMIT     = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [OpW-1:0]     op_q, op_d;
  logic [StatusW-1:0] code_q, code_d;
  logic               walk_end;

  assign walk_end    = sts_i.link_is_head || sts_i.cnt_end;
  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d             = state_q;
    op_d                = op_q;
    code_d              = code_q;
    cmd_o.ld_req        = 1'b0;
    cmd_o.rd_head       = 1'b0;
    cmd_o.rd_next       = 1'b0;
    cmd_o.save_node     = 1'b0;
    cmd_o.wr_op         = WR_NONE;
    cmd_o.emit          = 1'b0;
    cmd_o.emit_item     = 1'b0;
    cmd_o.emit_status   = ST_OK;
    cmd_o.emit_last     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.ld_req  = 1'b1;
          cmd_o.rd_head = 1'b1;
          op_d          = req_op_i;
          priority if (req_op_i == OP_FIRST || req_op_i == OP_LAST) begin
            if (sts_i.full) begin
              code_d  = ST_FULL;
              state_d = S_EMIT;
            end else if (!sts_i.nonempty) begin
              state_d = S_SOLO;
            end else begin
              state_d = S_TAIL;
            end
          end else if (req_op_i == OP_AFTER || req_op_i == OP_BEFORE) begin
            if (!sts_i.nonempty) begin
              code_d  = ST_EMPTY;
              state_d = S_EMIT;
            end else begin
              state_d = S_SRCH;
            end
          end else if (req_op_i == OP_LIST) begin
            if (!sts_i.nonempty) begin
              code_d  = ST_EMPTY;
              state_d = S_EMIT;
            end else begin
              state_d = S_LIST;
            end
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SOLO: begin
        cmd_o.wr_op = WR_SOLO;
        code_d      = ST_OK;
        state_d     = S_EMIT;
      end
      S_TAIL: begin
        if (walk_end) begin
          cmd_o.save_node = 1'b1;
          cmd_o.wr_op     = WR_NEW_HEAD;
          state_d         = S_LNK_TGT;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      S_SRCH: begin
        priority if (sts_i.val_match) begin
          cmd_o.save_node = 1'b1;
          priority if (sts_i.full) begin
            code_d  = ST_FULL;
            state_d = S_EMIT;
          end else if (op_q == OP_AFTER) begin
            cmd_o.wr_op = WR_NEW_PLINK;
            state_d     = S_LNK_TGT;
          end else if (sts_i.cur_is_head) begin
            cmd_o.rd_head = 1'b1;
            state_d       = S_TAIL;
          end else begin
            cmd_o.wr_op = WR_NEW_P;
            state_d     = S_LNK_PREV;
          end
        end else if (walk_end) begin
          code_d  = ST_NOTFOUND;
          state_d = S_EMIT;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      S_LIST: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_item   = 1'b1;
          cmd_o.emit_status = ST_ITEM;
          cmd_o.emit_last   = walk_end;
          if (walk_end) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      S_LNK_TGT: begin
        cmd_o.wr_op = (op_q == OP_FIRST || op_q == OP_BEFORE) ? WR_TGT_HEAD : WR_TGT;
        code_d      = ST_OK;
        state_d     = S_EMIT;
      end
      S_LNK_PREV: begin
        cmd_o.wr_op = WR_PREV;
        code_d      = ST_OK;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = code_q;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_FIRST;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      code_q  <= code_d;
    end
  end

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result issued into an occupied output slot");

  a_alloc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_op == WR_SOLO || cmd_o.wr_op == WR_NEW_HEAD ||
     cmd_o.wr_op == WR_NEW_PLINK || cmd_o.wr_op == WR_NEW_P) |-> !sts_i.full)
    else $error("node allocated with the store full");

  a_one_read_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.rd_head && cmd_o.rd_next))
    else $error("conflicting read commands");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_req |=> (state_q != S_IDLE) || (op_q != OP_FIRST && op_q != OP_LAST &&
                                            op_q != OP_AFTER && op_q != OP_BEFORE &&
                                            op_q != OP_LIST))
    else $error("valid request produced no work");

endmodule

[rtl/core/clie_dp.sv]
module clie_dp #(
  parameter int CAPACITY = clie_pkg::DefCapacity
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [clie_pkg::ValueW-1:0] new_value_i,
  input  logic signed [clie_pkg::ValueW-1:0] match_value_i,
  input  clie_pkg::cmd_t                    cmd_i,
  output clie_pkg::sts_t                    sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [clie_pkg::StatusW-1:0]      out_status_o,
  output logic signed [clie_pkg::ValueW-1:0] out_item_o,
  output logic                              out_last_o
);
  import clie_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [ValueW-1:0] val_mem [CAPACITY];
  logic [IW-1:0]     lnk_mem [CAPACITY];

  logic [ValueW-1:0] val_rd_q;
  logic [IW-1:0]     lnk_rd_q;
  logic [IW-1:0]     head_q;
  logic              nonempty_q;
  logic [CW-1:0]     free_q;
  logic [IW-1:0]     cur_q, prev_q, cnt_q;
  logic [IW-1:0]     tgt_q, prevm_q, new_q;
  logic [ValueW-1:0] nv_q, mv_q;

  logic              out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [ValueW-1:0] out_item_q;
  logic              out_last_q;

  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     free_idx;
  logic              val_we, lnk_we;
  logic [IW-1:0]     lnk_wa, lnk_wd;
  logic              out_free;

  assign free_idx = free_q[IW-1:0];
  assign rd_en    = cmd_i.rd_head || cmd_i.rd_next;
  assign rd_addr  = cmd_i.rd_head ? head_q : lnk_rd_q;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    val_we = 1'b0;
    lnk_we = 1'b1;
    lnk_wa = free_idx;
    lnk_wd = free_idx;
    unique case (cmd_i.wr_op)
      WR_NONE: begin
        lnk_we = 1'b0;
      end
      WR_SOLO: begin
        val_we = 1'b1;
      end
      WR_NEW_HEAD: begin
        val_we = 1'b1;
        lnk_wd = head_q;
      end
      WR_NEW_PLINK: begin
        val_we = 1'b1;
        lnk_wd = lnk_rd_q;
      end
      WR_NEW_P: begin
        val_we = 1'b1;
        lnk_wd = cur_q;
      end
      WR_TGT, WR_TGT_HEAD: begin
        lnk_wa = tgt_q;
        lnk_wd = new_q;
      end
      WR_PREV: begin
        lnk_wa = prevm_q;
        lnk_wd = new_q;
      end
      default: begin
        lnk_we = 1'b0;
      end
    endcase
  end

  // store access
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[free_idx] <= nv_q;
    end
    if (lnk_we) begin
      lnk_mem[lnk_wa] <= lnk_wd;
    end
    if (rd_en) begin
      val_rd_q <= val_mem[rd_addr];
      lnk_rd_q <= lnk_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      nonempty_q  <= 1'b0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (val_we) begin
        free_q <= free_q + CW'(1);
      end
      if (cmd_i.wr_op == WR_SOLO) begin
        head_q     <= free_idx;
        nonempty_q <= 1'b1;
      end else if (cmd_i.wr_op == WR_TGT_HEAD) begin
        head_q <= new_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // walk pointers, request payload, saved nodes and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_req) begin
      nv_q <= new_value_i;
      mv_q <= match_value_i;
    end
    if (cmd_i.rd_head) begin
      cur_q  <= head_q;
      prev_q <= head_q;
      cnt_q  <= '0;
    end else if (cmd_i.rd_next) begin
      cur_q  <= lnk_rd_q;
      prev_q <= cur_q;
      cnt_q  <= cnt_q + IW'(1);
    end
    if (cmd_i.save_node) begin
      tgt_q   <= cur_q;
      prevm_q <= prev_q;
    end
    if (val_we) begin
      new_q <= free_idx;
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.emit_status;
      out_item_q   <= cmd_i.emit_item ? val_rd_q : '0;
      out_last_q   <= cmd_i.emit_last;
    end
  end

  assign sts_o.nonempty     = nonempty_q;
  assign sts_o.full         = (free_q >= CW'(CAPACITY));
  assign sts_o.link_is_head = (lnk_rd_q == head_q);
  assign sts_o.val_match    = (val_rd_q == mv_q);
  assign sts_o.cur_is_head  = (cur_q == head_q);
  assign sts_o.cnt_end      = (cnt_q == IW'(CAPACITY - 1));
  assign sts_o.out_free     = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_item_o   = out_item_q;
  assign out_last_o   = out_last_q;

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= CW'(CAPACITY))
    else $error("allocator ran past the store");

  a_nonempty_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nonempty_q |=> nonempty_q)
    else $error("list became empty");

  a_head_allocated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nonempty_q |-> (CW'(head_q) < free_q))
    else $error("head points at an unallocated entry");

endmodule

[rtl/core/circular_list_insert_engine.sv]
// circular linked list engine with a bump allocator (entries are never freed)
// input channel s_axis: one request per beat, opcode selects insert first,
// insert last, insert after a match, insert before a match, or list all
// output channel m_axis: result beats, tlast marks the final beat of a request
// an insert or error request gives one beat; list all gives one beat per node
// insert first or last walks node by node from the head to the tail; insert
// after or before searches node by node from the head, and an insert before the
// head node also walks on to the tail; list all gives one beat per cycle while
// the result slot is free or m_axis_tready is high; each node step reads the
// value and link stores once
// one request is worked at a time; s_axis_tready is high only between requests
// the result register lets the next request start while the last beat waits
// if m_axis_tready is low the pending beat is held; the engine stalls on its next beat
// reset empties the list and the allocator; store contents are left as they are
module circular_list_insert_engine #(
  parameter int CAPACITY = clie_pkg::DefCapacity
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // opcode [2:0], new_value [34:3], match_value [66:35], zero pad [71:67]
  input  logic [clie_pkg::InTdataW-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status [2:0], item_value [34:3], zero pad [39:35]
  output logic [clie_pkg::OutTdataW-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);
  import clie_pkg::*;

  localparam int PadW = OutTdataW - StatusW - ValueW;

  cmd_t               cmd;
  sts_t               sts;
  logic               req_ready;
  logic [StatusW-1:0] out_status;
  logic [ValueW-1:0]  out_item;

  assign s_axis_tready = req_ready;

  clie_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_op_i    (s_axis_tdata[OpW-1:0]),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  clie_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .new_value_i   (s_axis_tdata[OpW +: ValueW]),
    .match_value_i (s_axis_tdata[OpW + ValueW +: ValueW]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_status_o  (out_status),
    .out_item_o    (out_item),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {{PadW{1'b0}}, out_item, out_status};

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import clie_pkg::*;

  localparam int CAP = DefCapacity;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 215;
  localparam logic [OpW-1:0] OP_TOP = 3'd7;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  value;
    logic               last;
  } reply_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InTdataW-1:0]    s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutTdataW-1:0]   m_axis_tdata;
  logic                   m_axis_tlast;

  // shadow of the list held by the engine
  logic [ValueW-1:0] node_val [CAP];
  int                node_link [CAP];
  int                head_q = 0;
  bit                filled = 1'b0;
  int                alloc_cnt = 0;

  reply_t due_replies [$];

  bit no_idle = 1'b0;
  int rx_hold = 0;
  int errors = 0;
  int n_sent = 0;
  int n_ignored = 0;
  int n_beats = 0;
  int n_full = 0;
  int n_lists = 0;
  int cycle_cnt = 0;

  circular_list_insert_engine #(
    .CAPACITY(CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats outstanding", $time, due_replies.size());
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic void add_reply(logic [StatusW-1:0] status, logic [ValueW-1:0] value,
                                    logic last);
    reply_t r;
    r.status = status;
    r.value  = value;
    r.last   = last;
    due_replies.push_back(r);
    if (status == ST_FULL) n_full++;
  endfunction

  function automatic int grab_node(logic [ValueW-1:0] v);
    int i;
    i = alloc_cnt;
    alloc_cnt++;
    node_val[i] = v;
    return i;
  endfunction

  function automatic int tail_of();
    int p;
    p = head_q;
    for (int n = 0; n < CAP; n++) begin
      if (node_link[p] == head_q) break;
      p = node_link[p];
    end
    return p;
  endfunction

  // insert at the head or the tail of the ring
  function automatic void join_end(logic [ValueW-1:0] v, bit make_head);
    int i, t;
    i = grab_node(v);
    if (!filled) begin
      head_q = i;
      node_link[i] = i;
      filled = 1'b1;
    end else begin
      t = tail_of();
      node_link[i] = head_q;
      node_link[t] = i;
      if (make_head) head_q = i;
    end
  endfunction

  function automatic void list_engine_apply(logic [OpW-1:0] op, logic [ValueW-1:0] nv,
                                            logic [ValueW-1:0] mv);
    int p, prev, nx, fresh;
    bit found, fin;
    case (op)
      OP_FIRST, OP_LAST: begin
        if (alloc_cnt >= CAP) begin
          add_reply(ST_FULL, '0, 1'b1);
        end else begin
          join_end(nv, op == OP_FIRST);
          add_reply(ST_OK, '0, 1'b1);
        end
      end
      OP_AFTER, OP_BEFORE: begin
        found = 1'b0;
        p = head_q;
        prev = p;
        if (!filled) begin
          add_reply(ST_EMPTY, '0, 1'b1);
          return;
        end
        for (int n = 0; n < CAP; n++) begin
          if (node_val[p] == mv) begin
            found = 1'b1;
            break;
          end
          prev = p;
          p = node_link[p];
          if (p == head_q) break;
        end
        if (!found) begin
          add_reply(ST_NOTFOUND, '0, 1'b1);
        end else if (alloc_cnt >= CAP) begin
          add_reply(ST_FULL, '0, 1'b1);
        end else begin
          if (op == OP_AFTER) begin
            fresh = grab_node(nv);
            node_link[fresh] = node_link[p];
            node_link[p] = fresh;
          end else if (p == head_q) begin
            join_end(nv, 1'b1);
          end else begin
            fresh = grab_node(nv);
            node_link[prev] = fresh;
            node_link[fresh] = p;
          end
          add_reply(ST_OK, '0, 1'b1);
        end
      end
      OP_LIST: begin
        n_lists++;
        if (!filled) begin
          add_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          p = head_q;
          for (int k = 0; k < CAP; k++) begin
            nx = node_link[p];
            fin = (nx == head_q) || (k == CAP - 1);
            add_reply(ST_ITEM, node_val[p], fin);
            if (fin) break;
            p = nx;
          end
        end
      end
      default: n_ignored++;
    endcase
  endfunction

  task automatic send_req(input logic [OpW-1:0] op, input logic [ValueW-1:0] nv,
                          input logic [ValueW-1:0] mv);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {{(InTdataW - OpW - 2 * ValueW){1'b0}}, mv, nv, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    list_engine_apply(op, nv, mv);
  endtask

  task automatic check_beat(input logic [OutTdataW-1:0] data, input logic tlast);
    reply_t want;
    n_beats++;
    if (due_replies.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual status %0d value %h last %b",
               $time, data[StatusW-1:0], data[StatusW+:ValueW], tlast);
      errors++;
      return;
    end
    want = due_replies.pop_front();
    if (data[StatusW-1:0] !== want.status) begin
      $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status,
               data[StatusW-1:0]);
      errors++;
    end
    if (data[StatusW+:ValueW] !== want.value) begin
      $display("%0t: item_value mismatch, expected %h, actual %h", $time, want.value,
               data[StatusW+:ValueW]);
      errors++;
    end
    if (tlast !== want.last) begin
      $display("%0t: tlast mismatch, expected %b, actual %b", $time, want.last, tlast);
      errors++;
    end
    if (data[OutTdataW-1:StatusW+ValueW] !== '0) begin
      $display("%0t: pad mismatch, expected 0, actual %h", $time,
               data[OutTdataW-1:StatusW+ValueW]);
      errors++;
    end
  endtask

  // result side: check each beat and draw the stall before the next one
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      check_beat(m_axis_tdata, m_axis_tlast);
      rx_hold = draw_gap();
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    m_axis_tready <= rst_ni && (rx_hold == 0);
  end

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3, 4: return 32'($urandom_range(0, 7));
      default: return $urandom();
    endcase
  endfunction

  // mostly a value already in the list, so that searches hit
  function automatic logic [ValueW-1:0] pick_key();
    if (alloc_cnt > 0 && $urandom_range(0, 9) < 7) return node_val[$urandom_range(0, alloc_cnt - 1)];
    return pick_value();
  endfunction

  function automatic logic [OpW-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return OP_FIRST;
    if (r < 30) return OP_LAST;
    if (r < 50) return OP_AFTER;
    if (r < 70) return OP_BEFORE;
    if (r < 90) return OP_LIST;
    return 3'($urandom_range(OP_LIST + 1, OP_TOP));
  endfunction

  task automatic test_empty_list();
    send_req(OP_LIST, '0, '0);
    send_req(OP_AFTER, 32'd1, 32'd2);
    send_req(OP_BEFORE, 32'd3, 32'h8000_0000);
    for (int c = int'(OP_LIST) + 1; c <= int'(OP_TOP); c++) begin
      send_req(3'(c), 32'hffff_ffff, 32'hffff_ffff);
    end
  endtask

  task automatic test_head_tail();
    send_req(OP_LAST, 32'h7fff_ffff, '0);
    send_req(OP_FIRST, 32'h8000_0000, '0);
    send_req(OP_LAST, 32'h0000_0000, '0);
    send_req(OP_FIRST, 32'hffff_ffff, '0);
    send_req(OP_LIST, '0, '0);
  endtask

  task automatic test_after_before();
    send_req(OP_AFTER, 32'd5, 32'h0000_0000);
    send_req(OP_BEFORE, 32'd6, 32'hffff_ffff);
    send_req(OP_BEFORE, 32'd7, 32'h7fff_ffff);
    send_req(OP_AFTER, 32'd8, 32'h8000_0000);
    send_req(OP_BEFORE, 32'd9, 32'h7fff_fffe);
    send_req(OP_AFTER, 32'd9, 32'h0001_0000);
    send_req(OP_LIST, '0, '0);
  endtask

  task automatic test_duplicates();
    send_req(OP_LAST, 32'd5, '0);
    send_req(OP_AFTER, 32'd10, 32'd5);
    send_req(OP_BEFORE, 32'd11, 32'd5);
    send_req(OP_LIST, '0, '0);
  endtask

  task automatic test_random_mix();
    int i;
    i = 0;
    while (n_sent - n_ignored < RANDOM_ITEMS) begin
      if (i % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_req(pick_op(), pick_value(), pick_key());
      i++;
    end
    no_idle = 1'b0;
  endtask

  task automatic test_store_full();
    while (alloc_cnt < CAP) send_req(OP_LAST, pick_value(), '0);
    send_req(OP_FIRST, pick_value(), '0);
    send_req(OP_LAST, pick_value(), '0);
    send_req(OP_AFTER, pick_value(), node_val[0]);
    send_req(OP_BEFORE, pick_value(), node_val[CAP - 1]);
    send_req(OP_AFTER, pick_value(), $urandom());
    send_req(OP_LIST, '0, '0);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_head_tail();
    test_after_before();
    test_duplicates();
    test_random_mix();
    test_store_full();
    s_axis_tvalid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (CAP + 40) @(posedge clk_i);
    $display("sent %0d requests (%0d with undefined opcodes), %0d list walks", n_sent,
             n_ignored, n_lists);
    $display("checked %0d result beats, %0d store-full replies", n_beats, n_full);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[circular_list_insert_engine.f]
rtl/core/clie_pkg.sv
rtl/core/clie_ctrl.sv
rtl/core/clie_dp.sv
rtl/core/circular_list_insert_engine.sv
tb/tb.sv
